@@ design/pva_pkg.sv @@
// Package for the polyphonic voice allocator: constants, state type and note arithmetic.
package pva_pkg;

  // Default number of voices in the voice table.
  localparam int unsigned PVA_VOICES = 18;

  // Field widths of the event and result items.
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned VOICE_W  = 5;
  localparam int unsigned PITCH_W  = 4;
  localparam int unsigned OCTAVE_W = 5;
  localparam int unsigned COUNT_W  = 8;

  // Note arithmetic constants.
  localparam int unsigned NOTE_OFFSET      = 5;
  localparam int unsigned NOTES_PER_OCTAVE = 12;
  localparam int unsigned OCTAVE_BIAS      = 2;

  // Event operation codes.
  localparam logic OP_NOTE_OFF = 1'b0;
  localparam logic OP_NOTE_ON  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } pva_state_t;

  // Pitch class and octave block of one note.
  typedef struct packed {
    logic [PITCH_W-1:0]         pitch;
    logic signed [OCTAVE_W-1:0] octave;
  } pva_tone_t;

  // Split note+5 into (note+5)%12 and (note+5)/12-2. The quotient uses a
  // multiply by 171/2048, which is exact for the range 0..132.
  function automatic pva_tone_t note_to_tone(input logic [NOTE_W-1:0] note);
    logic [7:0]  shifted;
    logic [15:0] prod;
    logic [3:0]  quot;
    logic [7:0]  rem;
    pva_tone_t   tone;
    shifted     = 8'(note) + 8'(NOTE_OFFSET);
    prod        = 16'(shifted) * 16'd171;
    quot        = prod[14:11];
    rem         = shifted - 8'(8'(quot) * 8'(NOTES_PER_OCTAVE));
    tone.pitch  = rem[PITCH_W-1:0];
    tone.octave = OCTAVE_W'(5'(quot) - 5'(OCTAVE_BIAS));
    return tone;
  endfunction

endpackage

@@ design/polyphonic_voice_allocator.sv @@
// Polyphonic voice allocator: voice table sequencer around a voice-note RAM.
//
// The input channel carries note events (in_operation: 1 = note on,
// 0 = note off, in_note: note number). A note-on takes the lowest free
// voice; a note-off frees the lowest voice that holds the note. Each
// key event returns one item on the output channel with the voice, key
// state, pitch class, octave block and the activity count after it.
// Ignored events (note-on of note 0, note-on with every voice busy,
// note-off of a note not held) give no output item.
//
// An event is checked against the voice table one entry per cycle
// through the RAM's single read port until the first match or the
// last voice; its result then waits in the done state for the output
// register. A note-on of note 0 is dropped on acceptance, and only
// one event is in work at a time.
// The output register holds a result while out_stall is high; the next
// event is accepted meanwhile, and its own result waits for the slot.
// Reset marks every voice free (through per-voice valid bits, so no
// clearing pass is needed), clears the count and empties the output.
module polyphonic_voice_allocator #(
  parameter int unsigned VOICES = pva_pkg::PVA_VOICES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [pva_pkg::NOTE_W-1:0]           in_note,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pva_pkg::VOICE_W-1:0]          out_voice,
  output logic                                 out_key_on,
  output logic [pva_pkg::PITCH_W-1:0]          out_pitch_index,
  output logic signed [pva_pkg::OCTAVE_W-1:0]  out_octave_block,
  output logic [pva_pkg::COUNT_W-1:0]          out_active_count
);

  import pva_pkg::*;

  localparam int unsigned AW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned VW   = (AW > VOICE_W) ? AW : VOICE_W;
  localparam logic [AW-1:0] LAST = AW'(VOICES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  pva_state_t         state_r, state_nxt;
  logic               op_r;
  logic [NOTE_W-1:0]  note_r;
  logic [NOTE_W-1:0]  key_r;
  logic [AW-1:0]      rd_addr_r;
  logic               issue_r;
  logic               chk_vld_r;
  logic [AW-1:0]      chk_idx_r;
  logic               found_r;
  logic [AW-1:0]      hit_idx_r;
  logic [VOICES-1:0]  vld_r;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               out_valid_r;
  logic [VOICE_W-1:0] out_voice_r;
  logic               out_key_on_r;
  logic [PITCH_W-1:0] out_pitch_r;
  logic signed [OCTAVE_W-1:0] out_octave_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               accept;
  logic               ignore_evt;
  logic [NOTE_W-1:0]  ram_rdata;
  logic [NOTE_W-1:0]  entry;
  logic               hit;
  logic               scan_end;
  logic               out_free;
  logic               finish;
  logic               out_load;
  logic               ram_we;
  logic [NOTE_W-1:0]  ram_wdata;
  logic [VW-1:0]      voice_wide;
  pva_tone_t          tone;

  // Voice-note storage.
  pva_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_idx_r),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Event acceptance; a note-on of note 0 is taken and dropped at once.
  assign accept     = in_valid && !in_stall;
  assign ignore_evt = (in_operation == OP_NOTE_ON) && (in_note == '0);

  // Compare the entry read last cycle; a never-written voice reads as free.
  assign entry    = vld_r[chk_idx_r] ? ram_rdata : '0;
  assign hit      = chk_vld_r && (entry == key_r);
  assign scan_end = chk_vld_r && (chk_idx_r == LAST);

  // The output slot can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !ignore_evt) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!found_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and control logic of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    finish   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_SCAN: in_stall = 1'b1;
      ST_DONE: begin
        finish   = !found_r || out_free;
        out_load = found_r && out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Table write-back: a note-on stores the note, a note-off frees the voice.
  assign ram_we    = out_load;
  assign ram_wdata = (op_r == OP_NOTE_ON) ? note_r : '0;

  // Activity count: saturating rise on note-on, floored fall on note-off.
  always_comb begin
    count_nxt = count_r;
    if (op_r == OP_NOTE_ON) begin
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end else if (count_r != '0) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Result fields.
  assign tone       = note_to_tone(note_r);
  assign voice_wide = VW'(hit_idx_r);

  // Sequencer and scan control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      issue_r   <= 1'b0;
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= (state_r == ST_SCAN) && issue_r && !hit;
      if (state_r == ST_IDLE && accept && !ignore_evt) begin
        issue_r <= 1'b1;
        found_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (hit || rd_addr_r == LAST) begin
          issue_r <= 1'b0;
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers of the event in work, scan pointer and hit index.
  always_ff @(posedge clk) begin
    chk_idx_r <= rd_addr_r;
    if (state_r == ST_IDLE && accept) begin
      op_r      <= in_operation;
      note_r    <= in_note;
      key_r     <= (in_operation == OP_NOTE_ON) ? '0 : in_note;
      rd_addr_r <= '0;
    end else if (state_r == ST_SCAN && issue_r && rd_addr_r != LAST) begin
      rd_addr_r <= rd_addr_r + 1'b1;
    end
    if (hit) begin
      hit_idx_r <= chk_idx_r;
    end
  end

  // Voice valid bits and activity count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      count_r <= '0;
    end else begin
      if (ram_we) begin
        vld_r[hit_idx_r] <= 1'b1;
      end
      if (finish) begin
        count_r <= count_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_voice_r  <= voice_wide[VOICE_W-1:0];
      out_key_on_r <= op_r;
      out_pitch_r  <= tone.pitch;
      out_octave_r <= tone.octave;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_voice        = out_voice_r;
  assign out_key_on       = out_key_on_r;
  assign out_pitch_index  = out_pitch_r;
  assign out_octave_block = out_octave_r;
  assign out_active_count = out_count_r;

  // The voice table is not modified while a scan is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(vld_r))
    else $error("voice valid bits changed during a scan");

  // A result is only produced for an event that found its voice.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (found_r && state_r == ST_DONE))
    else $error("result loaded without a matching voice");

  // A found voice lies inside the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && found_r) |-> (hit_idx_r <= LAST))
    else $error("voice index out of range");

  // A key-on result always reports a nonzero activity count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_on) |-> (out_active_count != '0))
    else $error("key-on result with zero activity count");

endmodule

@@ design/pva_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ dv/testbench.sv @@
// Testbench for the polyphonic voice allocator: random note events checked against a voice table model.
`timescale 1ns / 100ps

module testbench;
  import pva_pkg::*;

  localparam int unsigned RANDOM_EVENTS = 1900;
  localparam int unsigned STALL_LIMIT   = 1000;

  // One key event as it leaves the block.
  typedef struct packed {
    logic [VOICE_W-1:0]         voice;
    logic                       key_on;
    logic [PITCH_W-1:0]         pitch;
    logic signed [OCTAVE_W-1:0] octave;
    logic [COUNT_W-1:0]         count;
  } key_event_t;

  // Voice table model with the queue of key events it predicts.
  class voice_scoreboard;
    logic [NOTE_W-1:0]  voice_notes[PVA_VOICES];
    logic [COUNT_W-1:0] activity;
    key_event_t         pending_keys[$];
    int                 mismatches;

    function new();
      foreach (voice_notes[v]) voice_notes[v] = '0;
      activity   = '0;
      mismatches = 0;
    endfunction

    // Lowest voice whose entry equals the note; PVA_VOICES if none.
    function int find_voice(logic [NOTE_W-1:0] note);
      for (int v = 0; v < PVA_VOICES; v++) begin
        if (voice_notes[v] == note) return v;
      end
      return PVA_VOICES;
    endfunction

    // A note currently held somewhere in the table, or any note if none is.
    function logic [NOTE_W-1:0] pick_held();
      logic [NOTE_W-1:0] held[$];
      foreach (voice_notes[v]) begin
        if (voice_notes[v] != 0) held.push_back(voice_notes[v]);
      end
      if (held.size() == 0) return NOTE_W'($urandom_range(0, 127));
      return held[$urandom_range(0, held.size() - 1)];
    endfunction

    // Apply one accepted event and queue the key event it causes, if any.
    function void note_event(logic op, logic [NOTE_W-1:0] note);
      int         v;
      int         shifted;
      key_event_t ev;
      if (op == OP_NOTE_ON) begin
        if (note == 0) return;
        v = find_voice('0);
        if (activity != '1) activity++;
        if (v >= PVA_VOICES) return;
        voice_notes[v] = note;
      end else begin
        v = find_voice(note);
        if (activity != 0) activity--;
        if (v >= PVA_VOICES) return;
        voice_notes[v] = '0;
      end
      shifted   = int'(note) + int'(NOTE_OFFSET);
      ev.voice  = VOICE_W'(v);
      ev.key_on = op;
      ev.pitch  = PITCH_W'(shifted % int'(NOTES_PER_OCTAVE));
      ev.octave = OCTAVE_W'(shifted / int'(NOTES_PER_OCTAVE) - int'(OCTAVE_BIAS));
      ev.count  = activity;
      pending_keys.push_back(ev);
    endfunction

    function void report(string what, key_event_t exp_ev, key_event_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected voice %0d on %0d pitch %0d octave %0d count %0d",
                 $time, what, exp_ev.voice, exp_ev.key_on, exp_ev.pitch,
                 exp_ev.octave, exp_ev.count);
        $display("%0t: %s: actual   voice %0d on %0d pitch %0d octave %0d count %0d",
                 $time, what, got.voice, got.key_on, got.pitch, got.octave, got.count);
      end
    endfunction

    // Compare an output item with the oldest prediction.
    function void check_result(key_event_t got);
      key_event_t exp_ev;
      if (pending_keys.size() == 0) begin
        report("unexpected key event", '0, got);
        return;
      end
      exp_ev = pending_keys.pop_front();
      if (got.voice !== exp_ev.voice || got.key_on !== exp_ev.key_on ||
          got.pitch !== exp_ev.pitch || got.octave !== exp_ev.octave ||
          got.count !== exp_ev.count) begin
        report("key event mismatch", exp_ev, got);
      end
    endfunction

    function int pending();
      return pending_keys.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_operation = OP_NOTE_OFF;
  logic [NOTE_W-1:0]          in_note = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [VOICE_W-1:0]         out_voice;
  logic                       out_key_on;
  logic [PITCH_W-1:0]         out_pitch_index;
  logic signed [OCTAVE_W-1:0] out_octave_block;
  logic [COUNT_W-1:0]         out_active_count;

  bit              calm = 1'b0;
  int              quiet_cycles = 0;
  voice_scoreboard sb = new();

  polyphonic_voice_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_note          (in_note),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_voice        (out_voice),
    .out_key_on       (out_key_on),
    .out_pitch_index  (out_pitch_index),
    .out_octave_block (out_octave_block),
    .out_active_count (out_active_count)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random about ten percent of the time, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  // Check every accepted output item.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_voice, out_key_on, out_pitch_index, out_octave_block,
                       out_active_count});
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL polyphonic_voice_allocator");
      $finish;
    end
  end

  // Offer one note event, after an occasional gap, and hold it until accepted.
  task automatic send_event(input logic op, input logic [NOTE_W-1:0] note);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 10) gap = $urandom_range(1, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_note      <= note;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(op, note);
  endtask

  initial begin
    int                seg;
    int                on_pct;
    int                roll;
    logic              op;
    logic [NOTE_W-1:0] note;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored note-on, note-off of the free mark, range extremes, a miss,
    // a release, then fill every voice, overflow the table, and miss on note 0.
    send_event(OP_NOTE_ON, 7'd0);
    send_event(OP_NOTE_OFF, 7'd0);
    send_event(OP_NOTE_ON, 7'd127);
    send_event(OP_NOTE_ON, 7'd1);
    send_event(OP_NOTE_OFF, 7'd42);
    send_event(OP_NOTE_OFF, 7'd127);
    for (int k = 0; k < PVA_VOICES - 1; k++) begin
      send_event(OP_NOTE_ON, (k == 3) ? 7'd1 : NOTE_W'(6 + 7 * k));
    end
    send_event(OP_NOTE_ON, 7'd64);
    send_event(OP_NOTE_OFF, 7'd0);

    // Random: balanced, fill until the count saturates, drain to zero,
    // a calm stretch, then alternating fill and drain bursts.
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      seg  = i / 100;
      calm = (seg >= 11 && seg <= 13);
      if (seg < 3 || calm) on_pct = 50;
      else if (seg < 7) on_pct = 90;
      else if (seg < 11) on_pct = 10;
      else on_pct = seg[0] ? 85 : 15;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < on_pct) begin
        op = OP_NOTE_ON;
        if (roll < 4) note = '0;
        else if (roll < 30) note = NOTE_W'($urandom_range(60, 67));
        else note = NOTE_W'($urandom_range(1, 127));
      end else begin
        op = OP_NOTE_OFF;
        if (roll < 80) note = sb.pick_held();
        else note = NOTE_W'($urandom_range(0, 127));
      end
      send_event(op, note);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain the remaining key events, then give stray items time to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (PVA_VOICES + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS polyphonic_voice_allocator");
    end else begin
      $display("FAIL polyphonic_voice_allocator");
    end
    $finish;
  end

endmodule
